@@ rtl/tgme_pkg.sv @@
package tgme_pkg;

  localparam int FRAC_BITS = 16;
  localparam int EXP_DEPTH = 256;
  localparam int EXP_LOG   = $clog2(EXP_DEPTH);

  localparam int XW = 24;  // x, mean and sigma width
  localparam int GW = 39;  // gaussian term width, Q.(40-F)
  localparam int ZW = 20;  // z = |x-mu|/sigma, below 16.0
  localparam int TW = 23;
  localparam int PW = 32;
  localparam int NW = PW + EXP_LOG + 1 - 24;
  localparam int KW = NW - EXP_LOG;
  localparam int EW = 31;  // exp value, Q1.30

  localparam logic [24:0]   LOG2E_Q24   = 25'h1715477;
  localparam logic [30:0]   INV_SQRT2PI = 31'd1713444047;
  localparam logic [GW-1:0] G_MAX       = {GW{1'b1}};
  localparam logic [39:0]   LN2_Q40     = 40'hB17217F7D2;

  typedef enum logic [2:0] {
    REG_GAUSS1  = 3'd0,
    REG_GAUSS2  = 3'd1,
    REG_GAUSS3  = 3'd2,
    REG_NORM    = 3'd3,
    REG_WEIGHT1 = 3'd4,
    REG_WEIGHT2 = 3'd5
  } reg_index_t;

  typedef struct packed {
    logic zero;
    logic far;
  } term_flags_t;

  typedef struct packed {
    logic          valid;
    logic          sat;
    logic [GW-1:0] g;
  } term_res_t;

  typedef logic [EW-1:0] exp_rom_t [EXP_DEPTH];

  // shift and subtract quotient, used only while building the table
  function automatic longint unsigned div_u64(longint unsigned num, longint unsigned den);
    longint unsigned q;
    longint unsigned r;
    q = 64'd0;
    r = 64'd0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], num[b]};
      if (r >= den) begin
        r    = r - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // 2^(-j/depth) in Q1.30 from a truncated series
  function automatic exp_rom_t build_exp_rom();
    exp_rom_t          rom;
    longint unsigned   a;
    longint unsigned   sum;
    longint unsigned   term;
    for (int j = 0; j < EXP_DEPTH; j++) begin
      a    = ((longint'(LN2_Q40) * longint'(j)) >> EXP_LOG) >> 10;
      sum  = 64'd1 << 30;
      term = 64'd1 << 30;
      for (int n = 1; n <= 13; n++) begin
        term = div_u64((term * a) >> 30, longint'(n));
        if ((n % 2) == 1) sum = (sum >= term) ? sum - term : 64'd0;
        else sum = sum + term;
      end
      rom[j] = EW'(sum);
    end
    return rom;
  endfunction

  localparam exp_rom_t EXP_ROM = build_exp_rom();

endpackage

@@ rtl/tgme_div_pipe.sv @@
module tgme_div_pipe #(
  parameter int NUM_W = 40,
  parameter int DEN_W = 24,
  parameter int Q_W   = 20,
  parameter int PAY_W = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  input  logic [PAY_W-1:0] in_pay,
  output logic             out_valid,
  output logic [Q_W-1:0]   quo,
  output logic [PAY_W-1:0] out_pay
);
  localparam int CW = DEN_W + Q_W;

  logic [NUM_W-1:0] rem [Q_W+1];
  logic [Q_W-1:0]   qt  [Q_W+1];
  logic [PAY_W-1:0] pay [Q_W+1];
  logic             vld [Q_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= num;
      qt[0]  <= '0;
      pay[0] <= in_pay;
    end
  end

  // one quotient bit per stage, msb first
  for (genvar s = 0; s < Q_W; s++) begin : g_stage
    localparam int B = Q_W - 1 - s;
    logic [CW-1:0] trial;
    logic [CW-1:0] remx;
    logic          ge;

    always_comb begin
      trial = CW'(den) << B;
      remx  = CW'(rem[s]);
      ge    = (remx >= trial);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (en) begin
        vld[s+1] <= vld[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[s+1] <= ge ? NUM_W'(remx - trial) : rem[s];
        qt[s+1]  <= qt[s] | (Q_W'(ge) << B);
        pay[s+1] <= pay[s];
      end
    end
  end

  assign out_valid = vld[Q_W];
  assign quo       = qt[Q_W];
  assign out_pay   = pay[Q_W];

endmodule

@@ rtl/tgme_term.sv @@
module tgme_term (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [23:0]           x_value,
  input  logic [47:0]           mean_sigma,
  output tgme_pkg::term_res_t   res
);
  import tgme_pkg::*;

  logic [XW-1:0] mean;
  logic [XW-1:0] sigma;
  logic [XW-1:0] d;
  term_flags_t   fl_in;

  assign mean  = mean_sigma[47:24];
  assign sigma = mean_sigma[23:0];

  always_comb begin
    d           = (x_value >= mean) ? x_value - mean : mean - x_value;
    fl_in.zero  = (sigma == '0);
    fl_in.far   = ({4'b0, d} >= {sigma, 4'b0});
  end

  logic          z_valid;
  logic [ZW-1:0] z;
  logic [1:0]    z_pay;

  tgme_div_pipe #(
    .NUM_W(XW + FRAC_BITS), .DEN_W(XW), .Q_W(ZW), .PAY_W($bits(term_flags_t))
  ) u_zdiv (
    .clk(clk), .rst(rst), .en(en), .in_valid(in_valid),
    .num({d, {FRAC_BITS{1'b0}}}), .den(sigma), .in_pay(fl_in),
    .out_valid(z_valid), .quo(z), .out_pay(z_pay)
  );

  // t = z*z/2, then exponent in base 2
  logic          t_valid;
  logic [TW-1:0] t;
  term_flags_t   t_fl;
  logic [2*ZW-1:0] zz;
  assign zz = z * z;

  logic          p_valid;
  logic [PW-1:0] p;
  term_flags_t   p_fl;
  logic [TW+24:0] tl;
  assign tl = t * LOG2E_Q24;

  always_ff @(posedge clk) begin
    if (rst) begin
      t_valid <= 1'b0;
      p_valid <= 1'b0;
    end else if (en) begin
      t_valid <= z_valid;
      p_valid <= t_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t    <= zz[2*ZW-1:FRAC_BITS+1];
      t_fl <= z_pay;
      p    <= tl[TW+24:FRAC_BITS];
      p_fl <= t_fl;
    end
  end

  // round to 1/depth, table for the fraction, shift for the integer part
  logic [PW+EXP_LOG:0] pn;
  logic [NW-1:0]       n;
  logic [KW-1:0]       k;
  logic [EW-1:0]       e_next;

  always_comb begin
    pn = {1'b0, p, {EXP_LOG{1'b0}}} + (PW+EXP_LOG+1)'(64'd1 << 23);
    n  = pn[PW+EXP_LOG:24];
    k  = n[NW-1:EXP_LOG];
    if (k >= KW'(31)) e_next = '0;
    else e_next = EXP_ROM[n[EXP_LOG-1:0]] >> k[4:0];
  end

  logic          e_valid;
  logic [EW-1:0] e;
  term_flags_t   e_fl;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (en) begin
      e_valid <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e    <= e_next;
      e_fl <= p_fl;
    end
  end

  logic [2*EW-1:0] ep;
  assign ep = e * INV_SQRT2PI;

  logic          g_valid;
  logic [GW-1:0] gq;
  logic [1:0]    g_pay;
  term_flags_t   g_fl;

  tgme_div_pipe #(
    .NUM_W(2*EW - 22), .DEN_W(XW), .Q_W(GW), .PAY_W($bits(term_flags_t))
  ) u_gdiv (
    .clk(clk), .rst(rst), .en(en), .in_valid(e_valid),
    .num(ep[2*EW-1:22]), .den(sigma), .in_pay(e_fl),
    .out_valid(g_valid), .quo(gq), .out_pay(g_pay)
  );

  assign g_fl = g_pay;

  logic          res_valid;
  logic          res_sat;
  logic [GW-1:0] res_g;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (en) begin
      res_valid <= g_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_sat <= g_fl.zero;
      if (g_fl.zero) res_g <= G_MAX;
      else if (g_fl.far) res_g <= '0;
      else res_g <= gq;
    end
  end

  assign res = '{valid: res_valid, sat: res_sat, g: res_g};

endmodule

@@ rtl/triple_gaussian_mixture_eval.sv @@
// Three-component gaussian mixture density, one sample position per request.
// Sample channel: x_value (unsigned Q8.16) with sample_valid / sample_stall.
// Result channel: density (signed Q23.16) and saturated, with result_valid /
// result_stall. A request is taken at a clock edge with valid high and stall
// low. Configuration: cfg_write, cfg_index, cfg_data; write only while idle.
// One sample can be taken every cycle unless a stalled result holds the
// pipeline. The latency is set by the two bit-serial pipelined dividers
// per term (20 and 39 stages) plus the multiply, table and mixing stages.
// While the result is stalled the whole pipeline holds, so sample_stall
// follows result_stall whenever a result is waiting; nothing is lost.
// Reset (rst, synchronous) empties the pipeline and restores the registers:
// mean 0 and sigma 1.0 for all terms, norm 1.0, both weights 0.
// A zero sigma saturates its term and sets saturated; results beyond the
// Q23.16 range clamp and set saturated.
module triple_gaussian_mixture_eval (
  input  logic        clk,
  input  logic        rst,
  input  logic        sample_valid,
  output logic        sample_stall,
  input  logic [23:0] x_value,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [39:0] density,
  output logic        saturated,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data
);
  import tgme_pkg::*;

  logic [47:0] gauss1;
  logic [47:0] gauss2;
  logic [47:0] gauss3;
  logic [19:0] norm;
  logic [16:0] w1;
  logic [16:0] w2;

  always_ff @(posedge clk) begin
    if (rst) begin
      gauss1 <= 48'd65536;
      gauss2 <= 48'd65536;
      gauss3 <= 48'd65536;
      norm   <= 20'd256;
      w1     <= '0;
      w2     <= '0;
    end else if (cfg_write) begin
      case (reg_index_t'(cfg_index))
        REG_GAUSS1:  gauss1 <= cfg_data;
        REG_GAUSS2:  gauss2 <= cfg_data;
        REG_GAUSS3:  gauss3 <= cfg_data;
        REG_NORM:    norm   <= cfg_data[19:0];
        REG_WEIGHT1: w1     <= cfg_data[16:0];
        REG_WEIGHT2: w2     <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  logic en;
  assign en           = !(result_valid && result_stall);
  assign sample_stall = !en;

  term_res_t t1;
  term_res_t t2;
  term_res_t t3;

  tgme_term u_term1 (.clk(clk), .rst(rst), .en(en), .in_valid(sample_valid),
                     .x_value(x_value), .mean_sigma(gauss1), .res(t1));
  tgme_term u_term2 (.clk(clk), .rst(rst), .en(en), .in_valid(sample_valid),
                     .x_value(x_value), .mean_sigma(gauss2), .res(t2));
  tgme_term u_term3 (.clk(clk), .rst(rst), .en(en), .in_valid(sample_valid),
                     .x_value(x_value), .mean_sigma(gauss3), .res(t3));

  // third weight can go negative when the first two exceed 1.0
  logic signed [18:0] w3;
  assign w3 = 19'sd65536 - signed'({2'b0, w1}) - signed'({2'b0, w2});

  logic               m1_valid, m2_valid, m3_valid, m4_valid;
  logic               m1_sat, m2_sat, m3_sat, m4_sat;
  logic signed [57:0] m1_p1, m1_p2;
  logic signed [58:0] m1_p3;
  logic               m2_neg, m3_neg, m4_neg;
  logic [59:0]        m2_mag;
  logic [47:0]        m3_hi;
  logic [51:0]        m3_lo;
  logic [48:0]        m4_q;

  logic signed [60:0] mix;
  logic [48:0]        lim;
  logic [48:0]        q_sat;

  always_comb begin
    mix   = 61'(m1_p1) + 61'(m1_p2) + 61'(m1_p3);
    lim   = m4_neg ? 49'(64'd1 << 39) : 49'((64'd1 << 39) - 1);
    q_sat = (m4_q > lim) ? lim : m4_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_valid     <= 1'b0;
      m2_valid     <= 1'b0;
      m3_valid     <= 1'b0;
      m4_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else if (en) begin
      m1_valid     <= t1.valid;
      m2_valid     <= m1_valid;
      m3_valid     <= m2_valid;
      m4_valid     <= m3_valid;
      result_valid <= m4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_sat    <= t1.sat | t2.sat | t3.sat;
      m1_p1     <= signed'({1'b0, w1}) * signed'({1'b0, t1.g});
      m1_p2     <= signed'({1'b0, w2}) * signed'({1'b0, t2.g});
      m1_p3     <= w3 * signed'({1'b0, t3.g});
      m2_sat    <= m1_sat;
      m2_neg    <= mix[60];
      m2_mag    <= mix[60] ? 60'(-mix) : mix[59:0];
      m3_sat    <= m2_sat;
      m3_neg    <= m2_neg;
      m3_hi     <= norm * m2_mag[59:32];
      m3_lo     <= norm * m2_mag[31:0];
      m4_sat    <= m3_sat;
      m4_neg    <= m3_neg;
      m4_q      <= 49'(m3_hi) + 49'(m3_lo[51:32]);
      saturated <= m4_sat | (m4_q > lim);
      density   <= m4_neg ? 40'(-q_sat) : q_sat[39:0];
    end
  end

  a_zero_sigma_flags: assert property (@(posedge clk) disable iff (rst)
    result_valid && (gauss1[23:0] == '0) |-> saturated)
    else $error("zero sigma result not flagged");

  a_nonneg_weights: assert property (@(posedge clk) disable iff (rst)
    result_valid && ({1'b0, w1} + {1'b0, w2} <= 18'd65536) |-> !density[39])
    else $error("negative density with in-range weights");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> $stable(m4_q) && $stable(t1))
    else $error("pipeline moved while result stalled");

endmodule
